>>> design/shfr_pkg.sv
// ----------------------------------------------------------------------------
// shfr_pkg: shared types and constants for the sync header frame receiver
// Holds the frame layout, the CRC-16/MODBUS byte update and the queue item.
// ----------------------------------------------------------------------------
package shfr_pkg;

    // Frame layout
    localparam logic [4:0] POS_FIRST_BODY = 5'd4;
    localparam logic [4:0] POS_CRC_HI     = 5'd23;
    localparam logic [4:0] POS_CRC_LO     = 5'd24;
    localparam logic [4:0] POS_TRAILER_1  = 5'd25;
    localparam logic [4:0] POS_LAST       = 5'd26;

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SYNC_T      = 3'd0,
        CFG_SYNC_X      = 3'd1,
        CFG_SYNC_START  = 3'd2,
        CFG_TRAILER_1   = 3'd3,
        CFG_TRAILER_2   = 3'd4
    } cfg_idx_t;

    // Header hunt states
    typedef enum logic [2:0] {
        HUNT_IDLE,
        HUNT_T,
        HUNT_TX,
        HUNT_TXT,
        HUNT_COLLECT
    } hunt_state_t;

    // Match characters as seen by the front and back
    typedef struct packed {
        logic [7:0] sync_t;
        logic [7:0] sync_x;
        logic [7:0] sync_start;
    } sync_chars_t;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
    } trailer_chars_t;

    // One classified body byte passed from front to back
    typedef struct packed {
        logic [15:0] hdr_crc;   // CRC over the header, used at the first body byte
        logic [4:0]  pos;
        logic [7:0]  data;
    } q_item_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Fold one byte into a reflected CRC-16
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> design/shfr_front.sv
// ----------------------------------------------------------------------------
// shfr_front: header hunt and byte classifier
// Matches the four-byte sync header, folds the current header characters into
// a header CRC at the first body byte and tags each following body byte with
// its frame position before queueing it.
// ----------------------------------------------------------------------------
module shfr_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  shfr_pkg::sync_chars_t sync_chars,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_data,
    output logic                  q_push,
    output shfr_pkg::q_item_t     q_item,
    input  logic                  q_full
);
    import shfr_pkg::*;

    hunt_state_t state_reg, state_next;
    logic [4:0]  pos_reg, pos_next;
    logic [15:0] hdr_crc;
    logic        accept;
    logic        is_t;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign is_t     = (in_data == sync_chars.sync_t);

    // Header CRC from the register values current at this transfer; it is
    // linear in the 24 character bits, so it reduces to a shallow XOR tree
    assign hdr_crc = crc16_fold(crc16_fold(crc16_fold(crc16_fold(CRC_INIT,
                         sync_chars.sync_t), sync_chars.sync_x), sync_chars.sync_t),
                         sync_chars.sync_start);

    // Hold hunt state and frame position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= HUNT_IDLE;
            pos_reg   <= POS_FIRST_BODY;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // Advance the hunt; a T after a mismatch restarts the match
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        q_push     = 1'b0;
        q_item     = '{hdr_crc: hdr_crc, pos: pos_reg, data: in_data};
        if (accept) begin
            unique case (state_reg)
                HUNT_IDLE: begin
                    if (is_t) begin
                        state_next = HUNT_T;
                    end
                end
                HUNT_T, HUNT_TX, HUNT_TXT: begin
                    if ((state_reg == HUNT_T   && in_data == sync_chars.sync_x) ||
                        (state_reg == HUNT_TX  && is_t) ||
                        (state_reg == HUNT_TXT && in_data == sync_chars.sync_start)) begin
                        pos_next = POS_FIRST_BODY;
                        unique case (state_reg)
                            HUNT_T:  state_next = HUNT_TX;
                            HUNT_TX: state_next = HUNT_TXT;
                            default: state_next = HUNT_COLLECT;
                        endcase
                    end else if (is_t) begin
                        state_next = HUNT_T;
                    end else begin
                        state_next = HUNT_IDLE;
                    end
                end
                HUNT_COLLECT: begin
                    q_push = 1'b1;
                    if (pos_reg == POS_LAST) begin
                        state_next = HUNT_IDLE;
                    end else begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
                default: state_next = HUNT_IDLE;
            endcase
        end
    end

endmodule

>>> design/shfr_queue.sv
// ----------------------------------------------------------------------------
// shfr_queue: small FIFO between the classifier and the checker
// Lets the front keep taking bytes while the back waits on the output.
// ----------------------------------------------------------------------------
module shfr_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  shfr_pkg::q_item_t push_item,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output shfr_pkg::q_item_t pop_item
);
    import shfr_pkg::*;

    q_item_t                store [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = store[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !(pop && not_empty)) begin
            count_next = count_reg + (QUEUE_PTR_W+1)'(1);
        end else if (!push && pop && not_empty) begin
            count_next = count_reg - (QUEUE_PTR_W+1)'(1);
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop && not_empty) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Write the entry
    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/shfr_back.sv
// ----------------------------------------------------------------------------
// shfr_back: CRC and trailer check with output register
// Runs the CRC over body bytes, captures the received CRC and trailer match,
// and presents each byte with its status in a registered output stage.
// ----------------------------------------------------------------------------
module shfr_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  shfr_pkg::trailer_chars_t trailer_chars,
    input  logic                     q_valid,
    output logic                     q_pop,
    input  shfr_pkg::q_item_t        q_item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [7:0]               out_data,
    output logic [4:0]               out_pos,
    output logic                     out_last,
    output logic [2:0]               out_status   // crc_ok, trailer_ok, frame_good
);
    import shfr_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [15:0] rcv_crc_reg;
    logic        trl1_ok_reg;
    logic        valid_reg;
    logic [7:0]  data_reg;
    logic [4:0]  pos_reg;
    logic        last_reg;
    logic [2:0]  status_reg;
    logic [15:0] crc_base;
    logic        is_last, c_ok, t_ok;

    assign q_pop    = q_valid && (!valid_reg || out_ready);
    assign crc_base = (q_item.pos == POS_FIRST_BODY) ? q_item.hdr_crc : crc_reg;
    assign crc_next = crc16_fold(crc_base, q_item.data);
    assign is_last  = (q_item.pos == POS_LAST);
    assign c_ok     = (crc_reg == rcv_crc_reg);
    assign t_ok     = trl1_ok_reg && (q_item.data == trailer_chars.second);

    // Hold output valid until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Update check state and load the output payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            if (q_item.pos < POS_CRC_HI) begin
                crc_reg <= crc_next;
            end
            if (q_item.pos == POS_CRC_HI) begin
                rcv_crc_reg[15:8] <= q_item.data;
            end
            if (q_item.pos == POS_CRC_LO) begin
                rcv_crc_reg[7:0] <= q_item.data;
            end
            if (q_item.pos == POS_TRAILER_1) begin
                trl1_ok_reg <= (q_item.data == trailer_chars.first);
            end
            data_reg   <= q_item.data;
            pos_reg    <= q_item.pos;
            last_reg   <= is_last;
            status_reg <= is_last ? {c_ok && t_ok, t_ok, c_ok} : 3'b000;
        end
    end

    assign out_valid  = valid_reg;
    assign out_data   = data_reg;
    assign out_pos    = pos_reg;
    assign out_last   = last_reg;
    assign out_status = status_reg;

endmodule

>>> design/sync_header_frame_receiver_crc16_top.sv
// ----------------------------------------------------------------------------
// sync_header_frame_receiver_crc16_top: frame receiver with CRC-16/MODBUS
// Hunts a T X T start header in a byte stream and checks the 27-byte frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries received bytes in s_tdata[7:0]. Header bytes produce
//   no output; each body byte (positions 4..26) produces one transfer on the
//   m_ channel: m_tdata[7:0] byte value, m_tdata[12:8] position. m_tlast
//   marks position 26, where m_tuser gives {frame_good, trailer_ok, crc_ok};
//   m_tuser is zero on every other transfer.
//   The CRC covers positions 0..22 (header included) and is compared with
//   positions 23 (high) and 24 (low); positions 25 and 26 must equal the
//   trailer characters.
//   Configuration: cfg_we with cfg_addr 0..4 writes sync T, sync X, start,
//   first and second trailer character. Other addresses are ignored. Write
//   only while no frame is in flight.
//   Path: a body byte's input transfer writes the queue, then loads the
//   output register, which raises m_tvalid. Throughput: one byte per cycle
//   while m_tready is high and the queue is not full; the 8-bit CRC update
//   in the back end is combinational.
//   Stall: a 4-entry queue sits between classifier and checker; s_tready
//   falls only when it is full, so the input keeps flowing after m_tready
//   drops, until the queue fills.
//   Reset: synchronous, active low; clears the hunt to idle, empties the
//   queue and drops m_tvalid; config registers return to T=84 X=88 start=58,
//   trailer 82 and 78.
// ----------------------------------------------------------------------------
module sync_header_frame_receiver_crc16_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] byte_value, [12:8] byte_position
    output logic        m_tlast,    // frame_end
    output logic [2:0]  m_tuser,    // [0] crc_ok, [1] trailer_ok, [2] frame_good
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import shfr_pkg::*;

    sync_chars_t    sync_reg;
    trailer_chars_t trailer_reg;
    logic           q_push, q_full, q_pop, q_not_empty;
    q_item_t        q_in, q_out;
    logic [7:0]     out_data;
    logic [4:0]     out_pos;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg    <= '{sync_t: 8'd84, sync_x: 8'd88, sync_start: 8'd58};
            trailer_reg <= '{first: 8'd82, second: 8'd78};
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SYNC_T:     sync_reg.sync_t       <= cfg_wdata;
                CFG_SYNC_X:     sync_reg.sync_x       <= cfg_wdata;
                CFG_SYNC_START: sync_reg.sync_start   <= cfg_wdata;
                CFG_TRAILER_1:  trailer_reg.first     <= cfg_wdata;
                CFG_TRAILER_2:  trailer_reg.second    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    shfr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .sync_chars (sync_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .q_push     (q_push),
        .q_item     (q_in),
        .q_full     (q_full)
    );

    shfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_out)
    );

    shfr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .trailer_chars (trailer_reg),
        .q_valid       (q_not_empty),
        .q_pop         (q_pop),
        .q_item        (q_out),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_data      (out_data),
        .out_pos       (out_pos),
        .out_last      (m_tlast),
        .out_status    (m_tuser)
    );

    assign m_tdata = {3'b000, out_pos, out_data};

endmodule

>>> design/shfr_checker.sv
// ----------------------------------------------------------------------------
// shfr_checker: port-level checks for the frame receiver
// Watches the result channel for stall behavior and frame status coding.
// ----------------------------------------------------------------------------
module shfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic [2:0]  m_tuser
);
    import shfr_pkg::*;

    // Stalled transfer holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Status flags appear only on the frame end
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser == 3'b000)
        else $error("status set before frame end");

    // Frame end sits at the last position
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[12:8] == POS_LAST)
        else $error("frame end at wrong position");

    // Frame good is the conjunction of both checks
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[2] == (m_tuser[0] && m_tuser[1]))
        else $error("frame_good inconsistent");

    // Reset drops the output
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind sync_header_frame_receiver_crc16_top shfr_checker u_shfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

>>> tb/sv/sync_header_frame_receiver_crc16_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_header_frame_receiver_crc16_top_tb: self-checking bench for the frame receiver
// Streams header hunts, well-formed and damaged 27-byte frames and noise into
// the receiver. A behavioral model of the hunt, CRC-16/MODBUS and trailer check
// predicts every body byte and its status. A monitor compares each m_ transfer
// against the oldest prediction. Both sides stall at random, and the run also
// covers a long output hold-off and several register settings.
// ----------------------------------------------------------------------------
module sync_header_frame_receiver_crc16_top_tb;

    import shfr_pkg::*;

    localparam logic [15:0] MODBUS_SEED = 16'hFFFF;
    localparam logic [15:0] MODBUS_POLY = 16'hA001;
    localparam int          FRAME_BYTES = 27;
    localparam int          REPORT_MAX  = 10;

    // One predicted body byte, holding the fields of one m_ transfer
    typedef struct packed {
        logic [7:0] value;
        logic [4:0] pos;
        logic       frame_end;
        logic       crc_ok;
        logic       trailer_ok;
        logic       frame_good;
    } body_byte_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_BODY,
        FLAW_CRC,
        FLAW_TRAILER_1,
        FLAW_TRAILER_2,
        FLAW_TRUNCATED
    } frame_flaw_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [7:0]  cfg_wdata;

    // Model state and register copies
    sync_chars_t    sync_cfg;
    trailer_chars_t trailer_cfg;
    hunt_state_t    hunt_stage_m;
    logic [4:0]     next_pos_m;
    logic [15:0]    crc_acc_m;
    logic [15:0]    crc_rx_m;
    logic           trailer1_hit_m;

    body_byte_t expected_body_bytes[$];
    int         mismatch_count;
    int         counted_items;
    int         src_gap_max;
    int         sink_stall_max;
    int         hold_request;

    sync_header_frame_receiver_crc16_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case the receiver hangs
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Bit-serial reflected CRC update, LSB of the data first
    function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc,
                                                    input logic [7:0]  b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ MODBUS_POLY;
            end
        end
        return c;
    endfunction

    task automatic reset_frame_model();
        hunt_stage_m   = HUNT_IDLE;
        next_pos_m     = '0;
        crc_acc_m      = MODBUS_SEED;
        crc_rx_m       = '0;
        trailer1_hit_m = 1'b0;
    endtask

    // Advance the model by one accepted byte; queue the body byte it yields
    task automatic predict_rx_byte(input logic [7:0] b);
        body_byte_t r;
        logic [4:0] pos;
        if (hunt_stage_m != HUNT_COLLECT) begin
            if (!(hunt_stage_m == HUNT_IDLE && b != sync_cfg.sync_t)) begin
                counted_items++;
            end
            // a wrong header byte falls back to idle and is retried as a T
            if ((hunt_stage_m == HUNT_TXT && b != sync_cfg.sync_start) ||
                (hunt_stage_m == HUNT_TX  && b != sync_cfg.sync_t) ||
                (hunt_stage_m == HUNT_T   && b != sync_cfg.sync_x)) begin
                hunt_stage_m = HUNT_IDLE;
            end
            case (hunt_stage_m)
                HUNT_IDLE: begin
                    if (b == sync_cfg.sync_t) begin
                        hunt_stage_m = HUNT_T;
                    end
                end
                HUNT_T:  hunt_stage_m = HUNT_TX;
                HUNT_TX: hunt_stage_m = HUNT_TXT;
                default: begin
                    hunt_stage_m = HUNT_COLLECT;
                    next_pos_m   = POS_FIRST_BODY;
                end
            endcase
        end else begin
            counted_items++;
            pos     = next_pos_m;
            r       = '0;
            r.value = b;
            r.pos   = pos;
            // header folded from the current register values
            if (pos == POS_FIRST_BODY) begin
                crc_acc_m = MODBUS_SEED;
                crc_acc_m = modbus_crc_byte(crc_acc_m, sync_cfg.sync_t);
                crc_acc_m = modbus_crc_byte(crc_acc_m, sync_cfg.sync_x);
                crc_acc_m = modbus_crc_byte(crc_acc_m, sync_cfg.sync_t);
                crc_acc_m = modbus_crc_byte(crc_acc_m, sync_cfg.sync_start);
            end
            if (pos < POS_CRC_HI) begin
                crc_acc_m = modbus_crc_byte(crc_acc_m, b);
            end else if (pos == POS_CRC_HI) begin
                crc_rx_m = {b, 8'h00};
            end else if (pos == POS_CRC_LO) begin
                crc_rx_m = crc_rx_m | {8'h00, b};
            end else if (pos == POS_TRAILER_1) begin
                trailer1_hit_m = (b == trailer_cfg.first);
            end
            if (pos >= POS_LAST) begin
                r.frame_end  = 1'b1;
                r.crc_ok     = (crc_acc_m == crc_rx_m);
                r.trailer_ok = trailer1_hit_m && (b == trailer_cfg.second);
                r.frame_good = r.crc_ok && r.trailer_ok;
                reset_frame_model();
            end else begin
                next_pos_m = pos + 5'd1;
            end
            expected_body_bytes.push_back(r);
        end
    endtask

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        bit hs;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do begin
            @(negedge aclk);
            hs = s_tready;
            @(posedge aclk);
        end while (!hs);
        predict_rx_byte(b);
    endtask

    task automatic src_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_results_drained();
        while (expected_body_bytes.size() != 0) @(posedge aclk);
    endtask

    // Bring the receiver back to idle: finish any frame, break any header
    task automatic settle_idle();
        logic [7:0] filler;
        filler = 8'h00;
        while (filler == sync_cfg.sync_t || filler == sync_cfg.sync_x ||
               filler == sync_cfg.sync_start) begin
            filler++;
        end
        while (hunt_stage_m != HUNT_IDLE) send_byte(filler);
        src_idle();
        wait_results_drained();
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_SYNC_T:     sync_cfg.sync_t     = val;
            CFG_SYNC_X:     sync_cfg.sync_x     = val;
            CFG_SYNC_START: sync_cfg.sync_start = val;
            CFG_TRAILER_1:  trailer_cfg.first   = val;
            CFG_TRAILER_2:  trailer_cfg.second  = val;
            default: ;
        endcase
    endtask

    // Build a frame for the current registers, damage it as asked, send it
    task automatic send_frame(input frame_flaw_t flaw, input int pause_at);
        logic [7:0]  fr [FRAME_BYTES];
        logic [15:0] crc;
        int          cut;
        fr[0] = sync_cfg.sync_t;
        fr[1] = sync_cfg.sync_x;
        fr[2] = sync_cfg.sync_t;
        fr[3] = sync_cfg.sync_start;
        crc = MODBUS_SEED;
        for (int i = 0; i < 4; i++) crc = modbus_crc_byte(crc, fr[i]);
        for (int i = 4; i < 23; i++) begin
            fr[i] = 8'($urandom);
            crc   = modbus_crc_byte(crc, fr[i]);
        end
        fr[23] = crc[15:8];
        fr[24] = crc[7:0];
        fr[25] = trailer_cfg.first;
        fr[26] = trailer_cfg.second;
        cut = FRAME_BYTES;
        case (flaw)
            FLAW_BODY:      fr[$urandom_range(4, 22)] ^= 8'h01 << $urandom_range(0, 7);
            FLAW_CRC:       fr[$urandom_range(23, 24)] ^= 8'($urandom_range(1, 255));
            FLAW_TRAILER_1: fr[25] ^= 8'($urandom_range(1, 255));
            FLAW_TRAILER_2: fr[26] ^= 8'($urandom_range(1, 255));
            FLAW_TRUNCATED: cut = $urandom_range(1, FRAME_BYTES - 1);
            default: ;
        endcase
        for (int i = 0; i < cut; i++) begin
            if (i == pause_at) begin
                src_idle();
                wait_results_drained();
            end
            send_byte(fr[i]);
        end
    endtask

    // Random bytes, biased toward the header characters
    task automatic send_noise(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0:       b = sync_cfg.sync_t;
                1:       b = sync_cfg.sync_x;
                2:       b = sync_cfg.sync_start;
                default: b = 8'($urandom);
            endcase
            send_byte(b);
        end
    endtask

    // Mostly clean frames, some damaged or cut short, some noise
    task automatic run_traffic(input int n_items);
        int stop_at;
        int pick;
        stop_at = counted_items + n_items;
        while (counted_items < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                send_frame(FLAW_NONE, -1);
            end else if (pick < 8) begin
                send_frame(frame_flaw_t'($urandom_range(FLAW_BODY, FLAW_TRAILER_2)), -1);
            end else if (pick == 8) begin
                send_frame(FLAW_TRUNCATED, -1);
            end else begin
                send_noise($urandom_range(1, 12));
            end
        end
    endtask

    task automatic pick_idling();
        src_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 7;
        sink_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
    endtask

    // Compare one m_ transfer with the oldest prediction
    task automatic check_body_byte();
        body_byte_t want;
        body_byte_t got;
        got.value      = m_tdata[7:0];
        got.pos        = m_tdata[12:8];
        got.frame_end  = m_tlast;
        got.crc_ok     = m_tuser[0];
        got.trailer_ok = m_tuser[1];
        got.frame_good = m_tuser[2];
        if (expected_body_bytes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
                $display("%0t: unexpected body byte value=%h pos=%0d last=%b status=%b",
                         $time, got.value, got.pos, got.frame_end, m_tuser);
            end
        end else begin
            want = expected_body_bytes.pop_front();
            if (got !== want || m_tdata[15:13] !== 3'b000) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("%0t: expected value=%h pos=%0d last=%b good/tr/crc=%b%b%b",
                             $time, want.value, want.pos, want.frame_end,
                             want.frame_good, want.trailer_ok, want.crc_ok);
                    $display("%0t: actual   value=%h pos=%0d last=%b good/tr/crc=%b pad=%b",
                             $time, got.value, got.pos, got.frame_end, m_tuser,
                             m_tdata[15:13]);
                end
            end
        end
    endtask

    // Output side: sample at the falling edge, set ready at the rising edge
    initial begin : result_monitor
        int stall_left;
        int hold_left;
        bit took;
        stall_left = 0;
        hold_left  = 0;
        m_tready <= 1'b0;
        forever begin
            @(negedge aclk);
            took = m_tvalid && m_tready;
            if (took) begin
                check_body_byte();
            end
            @(posedge aclk);
            if (took) begin
                stall_left = $urandom_range(0, sink_stall_max);
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Header hunt corner cases with the reset characters
    task automatic test_header_hunt();
        logic [7:0] t;
        logic [7:0] x;
        logic [7:0] s;
        t = sync_cfg.sync_t;
        x = sync_cfg.sync_x;
        s = sync_cfg.sync_start;
        src_gap_max    = 0;
        sink_stall_max = 0;
        send_byte(8'h00);                 // idle ignores non-T bytes
        send_byte(8'hFF);
        send_byte(t); send_byte(8'h00);   // wrong X drops to idle
        send_byte(t); send_byte(t);       // T in the X slot restarts the hunt
        send_byte(x); send_byte(x);       // wrong third byte, not a T
        send_byte(t); send_byte(x); send_byte(t); send_byte(t);  // T in the start slot
        send_byte(x); send_byte(t); send_byte(8'hFF);            // wrong start
        send_byte(t); send_byte(x); send_byte(t); send_byte(s);  // full header
        send_byte(8'h00); send_byte(8'hFF); send_byte(t);        // body extremes
        settle_idle();
    endtask

    // Each frame flaw once, back to back, then each flaw but truncation with random idling
    task automatic test_frame_checks();
        src_gap_max    = 0;
        sink_stall_max = 0;
        for (int f = FLAW_NONE; f <= FLAW_TRUNCATED; f++) begin
            send_frame(frame_flaw_t'(f), -1);
        end
        send_frame(FLAW_NONE, -1);
        src_gap_max    = 7;
        sink_stall_max = 7;
        for (int f = FLAW_NONE; f <= FLAW_TRAILER_2; f++) begin
            send_frame(frame_flaw_t'(f), -1);
        end
        settle_idle();
    endtask

    // Hold the output off so the queue fills, then pause the input mid-frame
    task automatic test_flow_control();
        src_gap_max    = 0;
        sink_stall_max = 0;
        hold_request   = 120;
        send_frame(FLAW_NONE, -1);
        send_frame(FLAW_NONE, -1);
        send_frame(FLAW_NONE, 13);
        sink_stall_max = 7;
        hold_request   = 60;
        send_frame(FLAW_CRC, -1);
        settle_idle();
    endtask

    // Program all registers, poke the unused indexes, then run traffic
    task automatic apply_setting(input logic [7:0] t, input logic [7:0] x,
                                 input logic [7:0] s, input logic [7:0] tr1,
                                 input logic [7:0] tr2, input int n_items);
        settle_idle();
        write_cfg(CFG_SYNC_T, t);
        write_cfg(CFG_SYNC_X, x);
        write_cfg(CFG_SYNC_START, s);
        write_cfg(CFG_TRAILER_1, tr1);
        write_cfg(CFG_TRAILER_2, tr2);
        for (int a = CFG_TRAILER_2 + 1; a < (1 << CFG_ADDR_W); a++) begin
            write_cfg(3'(a), 8'($urandom));
        end
        pick_idling();
        run_traffic(n_items);
    endtask

    task automatic test_register_sweep();
        logic [7:0] v;
        v = 8'($urandom);
        apply_setting(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 120);
        apply_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 120);
        apply_setting(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 120);
        apply_setting(v, v, v, 8'($urandom), 8'($urandom), 120);
        for (int k = 0; k < 4; k++) begin
            apply_setting(8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom), 130);
        end
        settle_idle();
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_SYNC_T;
        cfg_wdata <= 8'h00;
        mismatch_count = 0;
        counted_items  = 0;
        src_gap_max    = 0;
        sink_stall_max = 0;
        hold_request   = 0;
        sync_cfg    = '{sync_t: 8'd84, sync_x: 8'd88, sync_start: 8'd58};
        trailer_cfg = '{first: 8'd82, second: 8'd78};
        reset_frame_model();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_header_hunt();
        test_frame_checks();
        test_flow_control();
        test_register_sweep();

        src_idle();
        wait_results_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && expected_body_bytes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
